@@ src/mlbt_pkg.sv @@
package mlbt_pkg;

	// Channel count of the bank (1 to 32); led_index reaches channels 0 to 7.
	localparam int unsigned NUM_CHANNELS = 8;

	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned INDEX_W  = 3;
	localparam int unsigned AMOUNT_W = 16;
	localparam int unsigned LEVELS_W = 8;

	// Channels that show up in led_levels.
	localparam int unsigned LEVELS_NUM = (NUM_CHANNELS < LEVELS_W) ? NUM_CHANNELS : LEVELS_W;

	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 16;

	localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_SET    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TOGGLE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_BLINK  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_BURST  = 3'd4;

	typedef logic [AMOUNT_W-1:0] ms_t;

endpackage

@@ src/multi_led_blink_burst_timer.sv @@
// Bank of LED channel timers. Each input item is a tick (elapsed ms in amount)
// or a command addressed by led_index: set level, toggle, start blink with a
// period, start burst for a duration. Every item yields one result item with
// the levels of all channels after the item took effect, plus a flag that
// marks a command naming a channel beyond the bank. The channel state is
// updated at the edge that accepts an item and the result is held in a
// single output register, so with the result side ready one item is taken
// per clock. The input side stalls only while that output register is full
// and not being drained. All channels advance in parallel on a tick, each
// with its own pair of 16-bit subtract/compare paths; a blink reload that would
// go below zero clamps to zero. After reset all LEDs are off and timing is
// disabled on every channel.
module multi_led_blink_burst_timer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] opcode, [5:3] led_index, [21:6] amount, [23:22] zero
	input  logic [mlbt_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] led_levels, [8] cmd_rejected, [15:9] zero
	output logic [mlbt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int unsigned N = mlbt_pkg::NUM_CHANNELS;

	// input field unpacking
	logic [mlbt_pkg::OPCODE_W-1:0] opcode;
	logic [mlbt_pkg::INDEX_W-1:0]  led_index;
	mlbt_pkg::ms_t                 amount;

	assign opcode    = s_tdata[2:0];
	assign led_index = s_tdata[5:3];
	assign amount    = s_tdata[21:6];

	// per-channel state
	mlbt_pkg::ms_t period_q [N];
	mlbt_pkg::ms_t rem_q    [N];
	logic          blink_q  [N];
	logic          level_q  [N];

	mlbt_pkg::ms_t period_n [N];
	mlbt_pkg::ms_t rem_n    [N];
	logic          blink_n  [N];
	logic          level_n  [N];

	logic accept;
	logic is_cmd;
	logic bad_index;
	logic rejected;
	logic do_tick;

	// output register
	logic                      out_vld_q;
	logic [mlbt_pkg::LEVELS_W-1:0] out_levels_q;
	logic                      out_rej_q;
	logic [mlbt_pkg::LEVELS_W-1:0] levels_n;

	assign s_tready = !out_vld_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign is_cmd    = (opcode == mlbt_pkg::OP_SET) || (opcode == mlbt_pkg::OP_TOGGLE) ||
	                   (opcode == mlbt_pkg::OP_BLINK) || (opcode == mlbt_pkg::OP_BURST);
	assign bad_index = (32'(led_index) >= N);
	assign rejected  = is_cmd && bad_index;
	assign do_tick   = (opcode == mlbt_pkg::OP_TICK) && (amount != '0);

	// Next state of every channel. Ticks touch all timed channels; commands only
	// the addressed one.
	always_comb begin
		mlbt_pkg::ms_t over;
		mlbt_pkg::ms_t reload;
		for (int i = 0; i < N; i++) begin
			period_n[i] = period_q[i];
			rem_n[i]    = rem_q[i];
			blink_n[i]  = blink_q[i];
			level_n[i]  = level_q[i];
			over        = amount - rem_q[i];
			reload      = (period_q[i] > over) ? (period_q[i] - over) : '0;
			if (do_tick && (period_q[i] != '0)) begin
				if (blink_q[i]) begin
					if (amount >= rem_q[i]) begin
						level_n[i] = !level_q[i];
						rem_n[i]   = reload;
					end else begin
						rem_n[i] = rem_q[i] - amount;
					end
				end else if (rem_q[i] != '0) begin
					if (amount < rem_q[i]) begin
						rem_n[i] = rem_q[i] - amount;
					end else begin
						rem_n[i]   = '0;
						level_n[i] = 1'b0;
					end
				end
			end else if (is_cmd && !bad_index && (32'(led_index) == i)) begin
				case (opcode)
					mlbt_pkg::OP_SET: begin
						period_n[i] = '0;
						level_n[i]  = (amount != '0);
					end
					mlbt_pkg::OP_TOGGLE: begin
						period_n[i] = '0;
						level_n[i]  = !level_q[i];
					end
					mlbt_pkg::OP_BLINK: begin
						period_n[i] = amount;
						blink_n[i]  = 1'b1;
					end
					mlbt_pkg::OP_BURST: begin
						period_n[i] = amount;
						rem_n[i]    = amount;
						blink_n[i]  = 1'b0;
						level_n[i]  = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		levels_n = '0;
		for (int i = 0; i < mlbt_pkg::LEVELS_NUM; i++) begin
			levels_n[i] = level_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				period_q[i] <= '0;
				rem_q[i]    <= '0;
				blink_q[i]  <= 1'b0;
				level_q[i]  <= 1'b0;
			end
		end else if (accept) begin
			for (int i = 0; i < N; i++) begin
				period_q[i] <= period_n[i];
				rem_q[i]    <= rem_n[i];
				blink_q[i]  <= blink_n[i];
				level_q[i]  <= level_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_levels_q <= levels_n;
			out_rej_q    <= rejected;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_rej_q, out_levels_q};

endmodule

@@ src/mlbt_checker.sv @@
module mlbt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [mlbt_pkg::IN_TDATA_W-1:0]     s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [mlbt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted item produces a result on the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item gave no result");

	// setting channel 0 on shows up in bit 0 of the next result
	a_set_level: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[2:0] == mlbt_pkg::OP_SET) &&
		(s_tdata[5:3] == 3'd0) && (s_tdata[21:6] != 16'd0) |=> m_tdata[0])
		else $error("set level not reflected");

	// ticks are never reported as rejected
	a_tick_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[2:0] == mlbt_pkg::OP_TICK) |=> !m_tdata[8])
		else $error("tick flagged as rejected");

endmodule

bind multi_led_blink_burst_timer mlbt_checker u_mlbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

	typedef logic [mlbt_pkg::OPCODE_W-1:0] opcode_t;
	typedef logic [mlbt_pkg::INDEX_W-1:0]  chan_t;

	// Opcodes 5 to 7 have no meaning; the block must leave every channel alone.
	localparam opcode_t OP_SPARE5 = 3'd5;
	localparam opcode_t OP_SPARE6 = 3'd6;
	localparam opcode_t OP_SPARE7 = 3'd7;

	localparam int WAIT_MAX     = 12;   // longest gap or stall per item
	localparam int IDLE_LIMIT   = 1000; // cycles with no item moving on either side
	localparam int RANDOM_ITEMS = 550;
	localparam int DIRECTED_N   = 25;
	localparam int SHOW_MAX     = 60;   // cap on printed mismatch lines

	localparam int SIDE_IN  = 0;
	localparam int SIDE_OUT = 1;

	typedef struct packed {
		logic                          rejected;
		logic [mlbt_pkg::LEVELS_W-1:0] levels;
	} led_result_t;

	// One row of the directed part. Where 'typed' is set, 'levels' is the result
	// that must come back (cmd_rejected is 0 on all of those rows); otherwise the
	// row is checked against the bank model below.
	typedef struct packed {
		opcode_t                       op;
		chan_t                         chan;
		mlbt_pkg::ms_t                 amt;
		logic                          typed;
		logic [mlbt_pkg::LEVELS_W-1:0] levels;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIRECTED_N] = '{
		// fresh out of reset: everything off
		'{mlbt_pkg::OP_TICK,   3'd0, 16'h0000, 1'b1, 8'h00},
		'{mlbt_pkg::OP_SET,    3'd0, 16'h0001, 1'b1, 8'h01},
		'{mlbt_pkg::OP_SET,    3'd7, 16'hffff, 1'b1, 8'h81},
		'{mlbt_pkg::OP_TOGGLE, 3'd7, 16'hffff, 1'b1, 8'h01},
		'{mlbt_pkg::OP_TOGGLE, 3'd3, 16'h0000, 1'b1, 8'h09},
		'{mlbt_pkg::OP_SET,    3'd3, 16'h0000, 1'b1, 8'h01},
		// spare opcodes do nothing and never reject
		'{OP_SPARE5,           3'd7, 16'hffff, 1'b1, 8'h01},
		'{OP_SPARE6,           3'd0, 16'h0000, 1'b1, 8'h01},
		'{OP_SPARE7,           3'd5, 16'h1234, 1'b1, 8'h01},
		// zero tick
		'{mlbt_pkg::OP_TICK,   3'd0, 16'h0000, 1'b1, 8'h01},
		// zero-length burst lights the LED but leaves timing off
		'{mlbt_pkg::OP_BURST,  3'd2, 16'h0000, 1'b1, 8'h05},
		'{mlbt_pkg::OP_BLINK,  3'd1, 16'd10,   1'b0, 8'h00},
		'{mlbt_pkg::OP_TICK,   3'd0, 16'd1,    1'b0, 8'h00},
		'{mlbt_pkg::OP_BURST,  3'd4, 16'd5,    1'b0, 8'h00},
		'{mlbt_pkg::OP_TICK,   3'd6, 16'd3,    1'b0, 8'h00},
		// huge tick: blink reload clamps at zero, burst runs out
		'{mlbt_pkg::OP_TICK,   3'd0, 16'hffff, 1'b0, 8'h00},
		// finished burst stays quiet
		'{mlbt_pkg::OP_TICK,   3'd0, 16'd1,    1'b0, 8'h00},
		'{mlbt_pkg::OP_BLINK,  3'd5, 16'hffff, 1'b0, 8'h00},
		'{mlbt_pkg::OP_TICK,   3'd0, 16'hffff, 1'b0, 8'h00},
		'{mlbt_pkg::OP_BLINK,  3'd6, 16'h0000, 1'b0, 8'h00},
		'{mlbt_pkg::OP_TICK,   3'd0, 16'd7,    1'b0, 8'h00},
		'{mlbt_pkg::OP_TOGGLE, 3'd1, 16'h0000, 1'b0, 8'h00},
		'{mlbt_pkg::OP_BURST,  3'd6, 16'd2,    1'b0, 8'h00},
		'{mlbt_pkg::OP_TICK,   3'd0, 16'd2,    1'b0, 8'h00},
		'{mlbt_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0, 8'h00}
	};

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [mlbt_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [mlbt_pkg::OUT_TDATA_W-1:0] m_tdata;

	// Bank model: a private copy of every channel's timing state.
	mlbt_pkg::ms_t chan_period [mlbt_pkg::NUM_CHANNELS];
	mlbt_pkg::ms_t chan_left   [mlbt_pkg::NUM_CHANNELS];
	logic          chan_blink  [mlbt_pkg::NUM_CHANNELS];
	logic          chan_on     [mlbt_pkg::NUM_CHANNELS];

	// Results owed by the block, oldest first.
	led_result_t levels_due [$];

	// Typed expectation riding along with the item currently offered.
	logic        pin_typed;
	led_result_t pin_result;

	led_result_t got_result;
	led_result_t want_result;
	led_result_t model_result;
	int          error_count = 0;
	int          idle_cycles = 0;
	int          quiet_left [2] = '{0, 0};

	multi_led_blink_burst_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Applies one item to the bank model and returns what the block must report.
	function automatic led_result_t led_bank_step(input opcode_t op, input chan_t chan,
			input mlbt_pkg::ms_t amt);
		led_result_t res;
		int unsigned over;
		res = '0;
		if (op == mlbt_pkg::OP_TICK) begin
			if (amt != '0) begin
				for (int i = 0; i < mlbt_pkg::NUM_CHANNELS; i++) begin
					if (chan_period[i] != '0) begin
						if (chan_blink[i]) begin
							if (amt >= chan_left[i]) begin
								// expired: flip, reload less the overshoot, floor at zero
								over = 32'(amt) - 32'(chan_left[i]);
								chan_on[i] = ~chan_on[i];
								chan_left[i] = (32'(chan_period[i]) > over) ?
									mlbt_pkg::ms_t'(32'(chan_period[i]) - over) : '0;
							end else begin
								chan_left[i] = chan_left[i] - amt;
							end
						end else if (chan_left[i] != '0) begin
							chan_left[i] = (amt < chan_left[i]) ? chan_left[i] - amt : '0;
							if (chan_left[i] == '0)
								chan_on[i] = 1'b0;
						end
					end
				end
			end
		end else if (op <= mlbt_pkg::OP_BURST) begin
			if (32'(chan) >= mlbt_pkg::NUM_CHANNELS) begin
				res.rejected = 1'b1;
			end else begin
				case (op)
					mlbt_pkg::OP_SET: begin
						chan_period[chan] = '0;
						chan_on[chan] = (amt != '0);
					end
					mlbt_pkg::OP_TOGGLE: begin
						chan_period[chan] = '0;
						chan_on[chan] = ~chan_on[chan];
					end
					mlbt_pkg::OP_BLINK: begin
						// remaining time carries over from whatever ran before
						chan_period[chan] = amt;
						chan_blink[chan] = 1'b1;
					end
					default: begin
						chan_period[chan] = amt;
						chan_left[chan] = amt;
						chan_blink[chan] = 1'b0;
						chan_on[chan] = 1'b1;
					end
				endcase
			end
		end
		for (int i = 0; i < mlbt_pkg::LEVELS_NUM; i++)
			res.levels[i] = chan_on[i];
		return res;
	endfunction

	// Cycles to wait before the next item on one side. Now and then a stretch
	// of back-to-back items so the block also runs at full rate.
	function automatic int draw_wait(input int side);
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet_left[side] = int'($urandom_range(8, 40));
			return 0;
		end
		return int'($urandom_range(0, WAIT_MAX));
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= SHOW_MAX)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Offers one item and returns at the edge where it is taken. s_tvalid stays
	// high into the next call unless that call starts with a gap.
	task automatic issue_item(input opcode_t op, input chan_t chan,
			input mlbt_pkg::ms_t amt, input logic typed,
			input logic [mlbt_pkg::LEVELS_W-1:0] levels);
		int gap;
		gap = draw_wait(SIDE_IN);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(mlbt_pkg::IN_TDATA_W - mlbt_pkg::OPCODE_W - mlbt_pkg::INDEX_W -
			mlbt_pkg::AMOUNT_W){1'b0}}, amt, chan, op};
		pin_typed <= typed;
		pin_result <= {1'b0, levels};
		do @(posedge clk); while (!s_tready);
	endtask

	// Result side: random stalls before each result.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(SIDE_OUT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Both handshakes are observed here. Results are checked before the item
	// taken at the same edge is modeled, so queue order follows the block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_result.levels = m_tdata[mlbt_pkg::LEVELS_W-1:0];
				got_result.rejected = m_tdata[mlbt_pkg::LEVELS_W];
				if (levels_due.size() == 0) begin
					report_error($sformatf("result %h with nothing outstanding", m_tdata));
				end else begin
					want_result = levels_due.pop_front();
					if (got_result.levels !== want_result.levels)
						report_error($sformatf("led_levels %h, want %h",
							got_result.levels, want_result.levels));
					if (got_result.rejected !== want_result.rejected)
						report_error($sformatf("cmd_rejected %b, want %b",
							got_result.rejected, want_result.rejected));
				end
			end
			if (s_tvalid && s_tready) begin
				model_result = led_bank_step(s_tdata[mlbt_pkg::OPCODE_W-1:0],
					s_tdata[mlbt_pkg::OPCODE_W +: mlbt_pkg::INDEX_W],
					s_tdata[mlbt_pkg::OPCODE_W+mlbt_pkg::INDEX_W +: mlbt_pkg::AMOUNT_W]);
				levels_due.push_back(pin_typed ? pin_result : model_result);
			end
			// watchdog: a hung handshake on either side ends the run
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int sel;
		int pick;
		opcode_t op;
		chan_t chan;
		mlbt_pkg::ms_t amt;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		pin_typed <= 1'b0;
		pin_result <= '0;
		for (int i = 0; i < mlbt_pkg::NUM_CHANNELS; i++) begin
			chan_period[i] = '0;
			chan_left[i] = '0;
			chan_blink[i] = 1'b0;
			chan_on[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_N; k++)
			issue_item(DIRECTED[k].op, DIRECTED[k].chan, DIRECTED[k].amt,
				DIRECTED[k].typed, DIRECTED[k].levels);

		// Random part. Periods and durations are mostly short and ticks small,
		// so timers actually expire, reload and overshoot; a few large values
		// keep the full amount range in play.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			sel = int'($urandom_range(0, 99));
			pick = int'($urandom_range(0, 9));
			chan = chan_t'($urandom_range(0, 7));
			amt = mlbt_pkg::ms_t'($urandom);
			if (sel < 45) begin
				op = mlbt_pkg::OP_TICK;
				if (pick == 0)
					amt = '0;
				else if (pick != 1)
					amt = mlbt_pkg::ms_t'($urandom_range(1, 24));
			end else if (sel < 55) begin
				op = mlbt_pkg::OP_SET;
				if (pick < 5)
					amt = '0;
			end else if (sel < 65) begin
				op = mlbt_pkg::OP_TOGGLE;
			end else if (sel < 95) begin
				op = (sel < 80) ? mlbt_pkg::OP_BLINK : mlbt_pkg::OP_BURST;
				if (pick == 0)
					amt = '0;
				else if (pick != 1)
					amt = mlbt_pkg::ms_t'($urandom_range(1, 40));
			end else begin
				op = opcode_t'($urandom_range(OP_SPARE5, OP_SPARE7));
			end
			issue_item(op, chan, amt, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then give the output register a few cycles to show anything extra
		@(posedge clk);
		while (levels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
